[rtl/epipolar_distance_stats_assert.svh]
// Assertion macros shared by the epipolar distance block.
`ifndef EPIPOLAR_DISTANCE_STATS_ASSERT_SVH
`define EPIPOLAR_DISTANCE_STATS_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication checked while out of reset
`define EDS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Next-cycle implication checked while out of reset
`define EDS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define EDS_ASSERT(lbl, clk, rst, prop, msg)
`define EDS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/eds_pkg.sv]
`default_nettype none
package eds_pkg;

   localparam int CoefW      = 32;
   localparam int CoordW     = 16;
   localparam int LineW      = 52;
   localparam int NumW       = 69;
   localparam int MacMulW    = 68;
   localparam int MacOpW     = 70;
   localparam int MacAccW    = 140;
   localparam int MacCntW    = 7;
   localparam int ShortSteps = 16;
   localparam int LongSteps  = 68;
   localparam int SqW        = 100;
   localparam int N2W        = 136;
   localparam int QuoW       = 33;
   localparam int DistW      = 16;
   localparam int SumW       = 32;
   localparam int CountW     = 16;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 64;

   localparam logic [CountW-1:0] MaxPairs = 16'hFFFF;
   localparam logic [DistW-1:0]  DistSat  = 16'hFFFF;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_COEF_11_12 = 3'd0,
      CSR_COEF_13_21 = 3'd1,
      CSR_COEF_22_23 = 3'd2,
      CSR_COEF_31_32 = 3'd3,
      CSR_COEF_33    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CoordW-1:0] left_x;
      logic [CoordW-1:0] left_y;
      logic [CoordW-1:0] right_x;
      logic [CoordW-1:0] right_y;
      logic              last_pair;
   } eds_req_type;

   typedef struct packed {
      logic [DistW-1:0]  distance;
      logic              degenerate;
      logic [DistW-1:0]  max_distance;
      logic [DistW-1:0]  mean_distance;
      logic [CountW-1:0] used_count;
      logic              done_res;
   } eds_rsp_type;

   // Command to the serial multiply-accumulate unit
   typedef struct packed {
      logic                     start;
      logic                     short_pass;
      logic [MacMulW-1:0]       u;
      logic [MacMulW-1:0]       v;
      logic signed [MacOpW-1:0] p;
      logic signed [MacOpW-1:0] q;
   } eds_mac_cmd_type;

   // Command to the statistics unit
   typedef struct packed {
      logic             update;
      logic [DistW-1:0] distance;
      logic             degenerate;
      logic             last_pair;
   } eds_stat_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETUP, ST_LIN_A, ST_LIN_B, ST_LIN_C, ST_LIN_N,
      ST_SQ_S, ST_SQ_N, ST_ROOT, ST_STAT, ST_OUT
   } seq_state_type;

   typedef enum logic [1:0] {RT_IDLE, RT_DIV, RT_SQRT} root_phase_type;

   typedef enum logic [1:0] {SS_IDLE, SS_MEAN} stat_phase_type;

   // 16 * coefficient, sign extended to the line width
   function automatic logic signed [LineW-1:0] coef_x16(input logic signed [CoefW-1:0] f);
      coef_x16 = {{(LineW-CoefW-4){f[CoefW-1]}}, f, 4'b0000};
   endfunction

endpackage
`default_nettype wire

[rtl/eds_mac.sv]
`default_nettype none
// Bit-serial multiply-accumulate: acc = u*p + v*q, one multiplier bit per
// cycle, most significant bit first.
module eds_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  eds_pkg::eds_mac_cmd_type              cmd,
   output logic                                  busy,
   output logic                                  done,
   output logic signed [eds_pkg::MacAccW-1:0]    acc
);
   import eds_pkg::*;

   logic [MacMulW-1:0]        u_ff, u_in, v_ff, v_in;
   logic signed [MacOpW-1:0]  p_ff, p_in, q_ff, q_in;
   logic signed [MacAccW-1:0] acc_ff, acc_in;
   logic [MacCntW-1:0]        cnt_ff, cnt_in;
   logic                      busy_ff, busy_in, done_ff, done_in;
   logic signed [MacAccW-1:0] p_term, q_term;

   // step: double and add the selected multiplicands
   always_comb begin
      p_term  = u_ff[MacMulW-1] ? MacAccW'(p_ff) : '0;
      q_term  = v_ff[MacMulW-1] ? MacAccW'(q_ff) : '0;
      u_in    = u_ff;
      v_in    = v_ff;
      p_in    = p_ff;
      q_in    = q_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         u_in    = cmd.short_pass ? {cmd.u[ShortSteps-1:0], {(MacMulW-ShortSteps){1'b0}}}
                                  : cmd.u;
         v_in    = cmd.short_pass ? {cmd.v[ShortSteps-1:0], {(MacMulW-ShortSteps){1'b0}}}
                                  : cmd.v;
         p_in    = cmd.p;
         q_in    = cmd.q;
         acc_in  = '0;
         cnt_in  = cmd.short_pass ? MacCntW'(ShortSteps) : MacCntW'(LongSteps);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (acc_ff <<< 1) + p_term + q_term;
         u_in   = u_ff << 1;
         v_in   = v_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == MacCntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff   <= u_in;
      v_ff   <= v_in;
      p_ff   <= p_in;
      q_ff   <= q_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign acc  = acc_ff;

endmodule
`default_nettype wire

[rtl/eds_root.sv]
`default_nettype none
// floor(sqrt(n2 / s)) saturated to 16 bits: restoring division, one quotient
// bit per cycle, then a bit-by-bit square root.
module eds_root (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [eds_pkg::N2W-1:0]      n2,
   input  logic [eds_pkg::SqW-1:0]      s,
   output logic                         done,
   output logic [eds_pkg::DistW-1:0]    sqrt_out
);
   import eds_pkg::*;

   root_phase_type     phase_ff, phase_in;
   logic [N2W-1:0]     rem_ff, rem_in, dvs_ff, dvs_in;
   logic [QuoW-1:0]    quo_ff, quo_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [DistW-1:0]   root_ff, root_in, bit_ff, bit_in, trial;
   logic [2*DistW-1:0] trial_sq;
   logic               done_ff, done_in, ge;

   always_comb begin
      ge       = rem_ff >= dvs_ff;
      trial    = root_ff | bit_ff;
      trial_sq = (2*DistW)'(trial) * (2*DistW)'(trial);
      phase_in = phase_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         RT_IDLE: begin
            if (start) begin
               rem_in   = n2;
               dvs_in   = N2W'({s, {(QuoW-1){1'b0}}});
               quo_in   = '0;
               cnt_in   = 6'(QuoW);
               phase_in = RT_DIV;
            end
         end
         // one quotient bit per cycle
         RT_DIV: begin
            if (ge) rem_in = rem_ff - dvs_ff;
            quo_in = {quo_ff[QuoW-2:0], ge};
            dvs_in = dvs_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 6'd1) begin
               root_in  = '0;
               bit_in   = {1'b1, {(DistW-1){1'b0}}};
               phase_in = RT_SQRT;
            end
         end
         // quotient of 2^32 or more saturates
         RT_SQRT: begin
            if (quo_ff[QuoW-1]) begin
               root_in  = DistSat;
               done_in  = 1'b1;
               phase_in = RT_IDLE;
            end else begin
               if (trial_sq <= quo_ff[QuoW-2:0]) root_in = trial;
               bit_in = bit_ff >> 1;
               if (bit_ff[0]) begin
                  done_in  = 1'b1;
                  phase_in = RT_IDLE;
               end
            end
         end
         default: phase_in = RT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= RT_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign done     = done_ff;
   assign sqrt_out = root_ff;

endmodule
`default_nettype wire

[rtl/eds_stats.sv]
`default_nettype none
// Running sum, maximum and count; serial mean division on the last pair.
module eds_stats (
   input  logic                        clock,
   input  logic                        reset,
   input  eds_pkg::eds_stat_cmd_type   cmd,
   output logic                        done,
   output eds_pkg::eds_rsp_type        rsp
);
   import eds_pkg::*;

   stat_phase_type    phase_ff, phase_in;
   logic [SumW-1:0]   sum_ff, sum_in, dvd_ff, dvd_in, new_sum;
   logic [DistW-1:0]  max_ff, max_in, new_max;
   logic [CountW-1:0] count_ff, count_in, new_count, rem_ff, rem_in;
   logic [CountW:0]   rem_sh;
   logic [5:0]        cnt_ff, cnt_in;
   eds_rsp_type       rsp_ff, rsp_in;
   logic              done_ff, done_in, counted, ge;

   always_comb begin
      counted   = !cmd.degenerate && (count_ff != MaxPairs);
      new_sum   = counted ? sum_ff + SumW'(cmd.distance) : sum_ff;
      new_max   = (counted && cmd.distance > max_ff) ? cmd.distance : max_ff;
      new_count = counted ? count_ff + 1'b1 : count_ff;
      rem_sh    = {rem_ff, dvd_ff[SumW-1]};
      ge        = rem_sh >= {1'b0, count_ff};
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      max_in    = max_ff;
      count_in  = count_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      rsp_in    = rsp_ff;
      done_in   = 1'b0;
      unique case (phase_ff)
         SS_IDLE: begin
            if (cmd.update) begin
               rsp_in.distance      = cmd.distance;
               rsp_in.degenerate    = cmd.degenerate;
               rsp_in.max_distance  = new_max;
               rsp_in.mean_distance = '0;
               rsp_in.used_count    = new_count;
               rsp_in.done_res      = cmd.last_pair;
               sum_in   = new_sum;
               max_in   = new_max;
               count_in = new_count;
               if (cmd.last_pair && new_count != '0) begin
                  dvd_in   = new_sum;
                  rem_in   = '0;
                  cnt_in   = 6'(SumW);
                  phase_in = SS_MEAN;
               end else begin
                  done_in = 1'b1;
                  if (cmd.last_pair) begin
                     sum_in   = '0;
                     max_in   = '0;
                     count_in = '0;
                  end
               end
            end
         end
         // restoring division, one quotient bit per cycle
         SS_MEAN: begin
            rem_in = ge ? CountW'(rem_sh - {1'b0, count_ff}) : CountW'(rem_sh);
            dvd_in = {dvd_ff[SumW-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 6'd1) begin
               rsp_in.mean_distance = {dvd_ff[DistW-2:0], ge};
               done_in  = 1'b1;
               sum_in   = '0;
               max_in   = '0;
               count_in = '0;
               phase_in = SS_IDLE;
            end
         end
         default: phase_in = SS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SS_IDLE;
         done_ff  <= 1'b0;
         sum_ff   <= '0;
         max_ff   <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
         sum_ff   <= sum_in;
         max_ff   <= max_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign done = done_ff;
   assign rsp  = rsp_ff;

endmodule
`default_nettype wire

[rtl/epipolar_distance_stats.sv]
// Each accepted pair goes through a setup step, four linear passes, two squaring
// passes, division and root, then statistics and output; a saturating distance
// skips the square root, a last pair with a nonzero count adds the serial mean
// division, and a degenerate line goes from the third linear pass to the statistics.
// One pair at a time; the next pair can be accepted in the cycle its result turns valid.
// Reset (synchronous, active high) clears coefficients, statistics and control.
`default_nettype none
`include "epipolar_distance_stats_assert.svh"
module epipolar_distance_stats (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  eds_pkg::eds_req_type              req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output eds_pkg::eds_rsp_type              rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [eds_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [eds_pkg::CsrDataW-1:0]      csr_data
);
   import eds_pkg::*;

   seq_state_type            state_ff, state_in;
   eds_req_type              item_ff, item_in;
   eds_rsp_type              rsp_payload_ff, rsp_payload_in, stat_rsp;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CsrDataW-1:0]      c1112_ff, c1321_ff, c2223_ff, c3132_ff;
   logic signed [CoefW-1:0]  c33_ff;
   logic signed [CoefW-1:0]  f11, f12, f13, f21, f22, f23, f31, f32;
   logic signed [LineW-1:0]  a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [NumW-1:0]   num_ff, num_in;
   logic [SqW-1:0]           s_ff, s_in;
   logic [LineW-1:0]         mag_a, mag_b;
   logic [NumW-1:0]          mag_num;
   eds_mac_cmd_type          mac_cmd;
   logic                     mac_busy, mac_done;
   logic signed [MacAccW-1:0] mac_acc;
   logic                     root_start, root_done;
   logic [DistW-1:0]         root_dist;
   eds_stat_cmd_type         stat_cmd;
   logic                     stat_done;

   assign f11 = c1112_ff[63:32];
   assign f12 = c1112_ff[31:0];
   assign f13 = c1321_ff[63:32];
   assign f21 = c1321_ff[31:0];
   assign f22 = c2223_ff[63:32];
   assign f23 = c2223_ff[31:0];
   assign f31 = c3132_ff[63:32];
   assign f32 = c3132_ff[31:0];

   assign mag_a   = a_ff[LineW-1] ? LineW'(-a_ff) : a_ff;
   assign mag_b   = b_ff[LineW-1] ? LineW'(-b_ff) : b_ff;
   assign mag_num = num_ff[NumW-1] ? NumW'(-num_ff) : num_ff;

   // coefficient registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         c1112_ff <= '0;
         c1321_ff <= '0;
         c2223_ff <= '0;
         c3132_ff <= '0;
         c33_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_COEF_11_12: c1112_ff <= csr_data;
            CSR_COEF_13_21: c1321_ff <= csr_data;
            CSR_COEF_22_23: c2223_ff <= csr_data;
            CSR_COEF_31_32: c3132_ff <= csr_data;
            CSR_COEF_33:    c33_ff   <= csr_data[CoefW-1:0];
            default: ;
         endcase
      end
   end

   // sequencer: line, numerator, squares, root, statistics, output
   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      c_in           = c_ff;
      num_in         = num_ff;
      s_in           = s_ff;
      mac_cmd        = '0;
      root_start     = 1'b0;
      stat_cmd       = '0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_payload;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            mac_cmd.start      = 1'b1;
            mac_cmd.short_pass = 1'b1;
            mac_cmd.u          = MacMulW'(item_ff.left_x);
            mac_cmd.v          = MacMulW'(item_ff.left_y);
            mac_cmd.p          = MacOpW'(f11);
            mac_cmd.q          = MacOpW'(f12);
            state_in           = ST_LIN_A;
         end
         ST_LIN_A: begin
            if (mac_done) begin
               a_in               = LineW'(mac_acc) + coef_x16(f13);
               mac_cmd.start      = 1'b1;
               mac_cmd.short_pass = 1'b1;
               mac_cmd.u          = MacMulW'(item_ff.left_x);
               mac_cmd.v          = MacMulW'(item_ff.left_y);
               mac_cmd.p          = MacOpW'(f21);
               mac_cmd.q          = MacOpW'(f22);
               state_in           = ST_LIN_B;
            end
         end
         ST_LIN_B: begin
            if (mac_done) begin
               b_in               = LineW'(mac_acc) + coef_x16(f23);
               mac_cmd.start      = 1'b1;
               mac_cmd.short_pass = 1'b1;
               mac_cmd.u          = MacMulW'(item_ff.left_x);
               mac_cmd.v          = MacMulW'(item_ff.left_y);
               mac_cmd.p          = MacOpW'(f31);
               mac_cmd.q          = MacOpW'(f32);
               state_in           = ST_LIN_C;
            end
         end
         // degenerate line skips straight to the statistics
         ST_LIN_C: begin
            if (mac_done) begin
               c_in = LineW'(mac_acc) + coef_x16(c33_ff);
               if (a_ff == '0 && b_ff == '0) begin
                  stat_cmd.update     = 1'b1;
                  stat_cmd.distance   = '0;
                  stat_cmd.degenerate = 1'b1;
                  stat_cmd.last_pair  = item_ff.last_pair;
                  state_in            = ST_STAT;
               end else begin
                  mac_cmd.start      = 1'b1;
                  mac_cmd.short_pass = 1'b1;
                  mac_cmd.u          = MacMulW'(item_ff.right_x);
                  mac_cmd.v          = MacMulW'(item_ff.right_y);
                  mac_cmd.p          = MacOpW'(a_ff);
                  mac_cmd.q          = MacOpW'(b_ff);
                  state_in           = ST_LIN_N;
               end
            end
         end
         ST_LIN_N: begin
            if (mac_done) begin
               num_in        = NumW'(mac_acc) + (NumW'(c_ff) <<< 4);
               mac_cmd.start = 1'b1;
               mac_cmd.u     = MacMulW'(mag_a);
               mac_cmd.v     = MacMulW'(mag_b);
               mac_cmd.p     = MacOpW'(mag_a);
               mac_cmd.q     = MacOpW'(mag_b);
               state_in      = ST_SQ_S;
            end
         end
         ST_SQ_S: begin
            if (mac_done) begin
               s_in          = mac_acc[SqW-1:0];
               mac_cmd.start = 1'b1;
               mac_cmd.u     = MacMulW'(mag_num);
               mac_cmd.p     = MacOpW'(mag_num);
               state_in      = ST_SQ_N;
            end
         end
         ST_SQ_N: begin
            if (mac_done) begin
               root_start = 1'b1;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               stat_cmd.update     = 1'b1;
               stat_cmd.distance   = root_dist;
               stat_cmd.degenerate = 1'b0;
               stat_cmd.last_pair  = item_ff.last_pair;
               state_in            = ST_STAT;
            end
         end
         ST_STAT: begin
            if (stat_done) state_in = ST_OUT;
         end
         // output register frees as soon as its transfer completes
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = stat_rsp;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      c_ff           <= c_in;
      num_ff         <= num_in;
      s_ff           <= s_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   eds_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .busy  (mac_busy),
      .done  (mac_done),
      .acc   (mac_acc)
   );

   eds_root u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .n2       (mac_acc[N2W-1:0]),
      .s        (s_ff),
      .done     (root_done),
      .sqrt_out (root_dist)
   );

   eds_stats u_stats (
      .clock (clock),
      .reset (reset),
      .cmd   (stat_cmd),
      .done  (stat_done),
      .rsp   (stat_rsp)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `EDS_ASSERT(a_mac_start_idle, clock, reset, mac_cmd.start |-> !mac_busy, "mac start while busy")
   `EDS_ASSERT(a_root_in_state, clock, reset, root_done |-> state_ff == ST_ROOT, "stray root done")
   `EDS_ASSERT(a_stat_in_state, clock, reset, stat_done |-> state_ff == ST_STAT, "stray stats done")
   `EDS_ASSERT_NEXT(a_out_holds, clock, reset, state_ff == ST_OUT && rsp_valid_ff && rsp_stall, state_ff == ST_OUT, "result dropped")

endmodule
`default_nettype wire
